[design/pcrw_pkg.sv]
// Shared types and constants for the power cycle recovery watchdog.
// No dependencies; used by every module of the block.
package pcrw_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CNT_W      = 8;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] REG_FAST_ATTEMPT_LIMIT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FAST_COOLDOWN_MS   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SLOW_COOLDOWN_MS   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_POWER_OFF_MS       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_CHECK_PERIOD_MS    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_FAILURE_LIMIT      = 3'd5;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_REBOOT = 1'b1;

   localparam logic [1:0] PHASE_CODE_MON  = 2'd0;
   localparam logic [1:0] PHASE_CODE_OFF  = 2'd1;
   localparam logic [1:0] PHASE_CODE_COOL = 2'd2;

   typedef enum logic [2:0] {
      PH_MON  = 3'b001,
      PH_OFF  = 3'b010,
      PH_COOL = 3'b100
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0]  fast_attempt_limit;
      logic [TIME_W-1:0] fast_cooldown_ms;
      logic [TIME_W-1:0] slow_cooldown_ms;
      logic [TIME_W-1:0] power_off_ms;
      logic [TIME_W-1:0] check_period_ms;
      logic [CNT_W-1:0]  failure_limit;
   } cfg_type;

   typedef struct packed {
      logic              cmd;
      logic [TIME_W-1:0] now_ms;
      logic              status_valid;
      logic              wifi_ok;
      logic              internet_ok;
      logic              coordinator_idle;
      logic              recovery_granted;
   } item_type;

   typedef struct packed {
      logic              relay_on;
      logic              check_request;
      logic              result_consumed;
      logic [CNT_W-1:0]  failure_count;
      logic [1:0]        recovery_phase;
      logic              reboot_accepted;
      logic              coordinator_start;
      logic              coordinator_finish;
      logic              can_request_reboot;
      logic              can_start_update;
   } result_type;

endpackage

[design/power_cycle_recovery_watchdog_top.sv]
// Power cycle recovery watchdog: input register, single-pass update, result register.
// Each accepted request beat passes the input register, then the result register, to its response beat.
// Throughput: one beat per cycle while rsp_tready is high; a stalled response beat holds both registers.
// Reset (synchronous, active high) empties both stages, returns the state to
// monitoring and loads the register defaults. Uses pcrw_pkg, pcrw_csr, pcrw_step.
module power_cycle_recovery_watchdog_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_ms[31:0], status_valid[32], wifi_ok[33], internet_ok[34],
   // coordinator_idle[35], recovery_granted[36], zero pad[39:37]
   input  logic [pcrw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // relay_on[0], check_request[1], result_consumed[2], failure_count[10:3],
   // recovery_phase[12:11], reboot_accepted[13], coordinator_start[14],
   // coordinator_finish[15], can_request_reboot[16], can_start_update[17], pad[23:18]
   output logic [pcrw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcrw_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pcrw_pkg::TIME_W-1:0]         csr_data
);

   pcrw_pkg::cfg_type     cfg;
   pcrw_pkg::item_type    item_ff, item_in;
   pcrw_pkg::result_type  result, result_ff;
   logic                  in_vld_ff, out_vld_ff;
   logic                  advance;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   assign item_in.cmd              = req_tuser;
   assign item_in.now_ms           = req_tdata[31:0];
   assign item_in.status_valid     = req_tdata[32];
   assign item_in.wifi_ok          = req_tdata[33];
   assign item_in.internet_ok      = req_tdata[34];
   assign item_in.coordinator_idle = req_tdata[35];
   assign item_in.recovery_granted = req_tdata[36];

   pcrw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pcrw_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'b0,
                        result_ff.can_start_update,
                        result_ff.can_request_reboot,
                        result_ff.coordinator_finish,
                        result_ff.coordinator_start,
                        result_ff.reboot_accepted,
                        result_ff.recovery_phase,
                        result_ff.failure_count,
                        result_ff.result_consumed,
                        result_ff.check_request,
                        result_ff.relay_on};

endmodule

[design/pcrw_csr.sv]
// Configuration register file of the watchdog.
// Depends on pcrw_pkg for the register indexes and the cfg_type struct.
module pcrw_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcrw_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pcrw_pkg::TIME_W-1:0]       csr_data,
   output pcrw_pkg::cfg_type                 cfg
);

   pcrw_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            pcrw_pkg::REG_FAST_ATTEMPT_LIMIT:
               cfg_in.fast_attempt_limit = csr_data[pcrw_pkg::CNT_W-1:0];
            pcrw_pkg::REG_FAST_COOLDOWN_MS: cfg_in.fast_cooldown_ms = csr_data;
            pcrw_pkg::REG_SLOW_COOLDOWN_MS: cfg_in.slow_cooldown_ms = csr_data;
            pcrw_pkg::REG_POWER_OFF_MS:     cfg_in.power_off_ms     = csr_data;
            pcrw_pkg::REG_CHECK_PERIOD_MS:  cfg_in.check_period_ms  = csr_data;
            pcrw_pkg::REG_FAILURE_LIMIT:
               cfg_in.failure_limit = csr_data[pcrw_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_attempt_limit <= 8'd3;
         cfg_ff.fast_cooldown_ms   <= 32'd120000;
         cfg_ff.slow_cooldown_ms   <= 32'd600000;
         cfg_ff.power_off_ms       <= 32'd10000;
         cfg_ff.check_period_ms    <= 32'd30000;
         cfg_ff.failure_limit      <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/pcrw_step.sv]
// Watchdog state and the single-pass update for one item.
// Depends on pcrw_pkg; state advances only when the top level moves a beat.
module pcrw_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  pcrw_pkg::item_type    item,
   input  pcrw_pkg::cfg_type     cfg,
   output pcrw_pkg::result_type  result
);

   pcrw_pkg::phase_type               phase_ff, phase_in;
   logic [pcrw_pkg::CNT_W-1:0]        failures_ff, failures_in;
   logic [pcrw_pkg::CNT_W-1:0]        attempts_ff, attempts_in;
   logic [pcrw_pkg::TIME_W-1:0]       deadline_ff, deadline_in;
   logic [pcrw_pkg::TIME_W-1:0]       last_check_ff, last_check_in;
   logic                              pending_ff, pending_in;

   always_comb begin
      logic [pcrw_pkg::TIME_W-1:0] now;
      logic [pcrw_pkg::TIME_W-1:0] diff;
      logic                        healthy;
      logic                        do_cycle;
      logic                        chk_req;
      logic                        consumed;
      logic                        accepted;
      logic                        co_start;
      logic                        co_finish;

      now           = item.now_ms;
      phase_in      = phase_ff;
      failures_in   = failures_ff;
      attempts_in   = attempts_ff;
      deadline_in   = deadline_ff;
      last_check_in = last_check_ff;
      pending_in    = pending_ff;
      healthy       = item.wifi_ok & item.internet_ok;
      do_cycle      = 1'b0;
      chk_req       = 1'b0;
      consumed      = 1'b0;
      accepted      = 1'b0;
      co_start      = 1'b0;
      co_finish     = 1'b0;
      diff          = '0;

      if (item.cmd == pcrw_pkg::CMD_REBOOT) begin
         if (phase_ff == pcrw_pkg::PH_MON && item.recovery_granted) begin
            do_cycle = 1'b1;
            accepted = 1'b1;
         end
      end else begin
         diff = now - deadline_in;
         if (phase_in == pcrw_pkg::PH_OFF && !diff[pcrw_pkg::TIME_W-1]) begin
            phase_in      = pcrw_pkg::PH_COOL;
            deadline_in   = now + ((attempts_in < cfg.fast_attempt_limit) ?
                                   cfg.fast_cooldown_ms : cfg.slow_cooldown_ms);
            last_check_in = '0;
         end
         if (item.status_valid) begin
            consumed   = 1'b1;
            pending_in = 1'b0;
            if (!healthy) begin
               if (failures_in < cfg.failure_limit) begin
                  failures_in = failures_in + 1'b1;
               end
            end else begin
               failures_in = '0;
            end
            if (healthy && phase_in == pcrw_pkg::PH_COOL) begin
               attempts_in = '0;
               phase_in    = pcrw_pkg::PH_MON;
               co_finish   = 1'b1;
            end else if (!healthy && phase_in == pcrw_pkg::PH_MON &&
                         failures_in >= cfg.failure_limit && item.coordinator_idle) begin
               co_start = 1'b1;
               do_cycle = 1'b1;
            end
         end
         diff = now - deadline_in;
         if (!do_cycle && phase_in == pcrw_pkg::PH_COOL && !diff[pcrw_pkg::TIME_W-1]) begin
            do_cycle = 1'b1;
         end
         diff = now - last_check_in;
         if (!pending_in && !(last_check_in != '0 && diff < cfg.check_period_ms)) begin
            last_check_in = now;
            pending_in    = 1'b1;
            chk_req       = 1'b1;
         end
      end

      if (do_cycle) begin
         if (attempts_in < cfg.fast_attempt_limit) begin
            attempts_in = attempts_in + 1'b1;
         end
         phase_in    = pcrw_pkg::PH_OFF;
         deadline_in = now + cfg.power_off_ms;
      end

      result.relay_on           = (phase_in == pcrw_pkg::PH_OFF);
      result.check_request      = chk_req;
      result.result_consumed    = consumed;
      result.failure_count      = failures_in;
      unique case (phase_in)
         pcrw_pkg::PH_OFF:  result.recovery_phase = pcrw_pkg::PHASE_CODE_OFF;
         pcrw_pkg::PH_COOL: result.recovery_phase = pcrw_pkg::PHASE_CODE_COOL;
         default:           result.recovery_phase = pcrw_pkg::PHASE_CODE_MON;
      endcase
      result.reboot_accepted    = accepted;
      result.coordinator_start  = co_start;
      result.coordinator_finish = co_finish;
      result.can_request_reboot = (phase_in == pcrw_pkg::PH_MON) &&
                                  (item.coordinator_idle || co_finish);
      result.can_start_update   = (phase_in == pcrw_pkg::PH_MON);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pcrw_pkg::PH_MON;
         failures_ff   <= '0;
         attempts_ff   <= '0;
         deadline_ff   <= '0;
         last_check_ff <= '0;
         pending_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         failures_ff   <= failures_in;
         attempts_ff   <= attempts_in;
         deadline_ff   <= deadline_in;
         last_check_ff <= last_check_in;
         pending_ff    <= pending_in;
      end
   end

endmodule

[design/pcrw_checker.sv]
// Port-level checks for the watchdog top level, bound onto every instance.
// Sees only the top level's ports; depends on pcrw_pkg for widths.
module pcrw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [pcrw_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pcrw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [pcrw_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input logic [pcrw_pkg::TIME_W-1:0]      csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   a_relay_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[12:11] == pcrw_pkg::PHASE_CODE_OFF)))
      else $error("relay state disagrees with recovery phase");

   a_monitor_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[17] == (rsp_tdata[12:11] == pcrw_pkg::PHASE_CODE_MON))
                      && (!rsp_tdata[16] || rsp_tdata[17])))
      else $error("monitoring flags disagree with recovery phase");

   a_start_enters_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[14] || rsp_tdata[13])
         |-> (rsp_tdata[12:11] == pcrw_pkg::PHASE_CODE_OFF) && !rsp_tdata[15])
      else $error("recovery start without power off");

endmodule

bind power_cycle_recovery_watchdog_top pcrw_checker u_pcrw_checker (.*);
